@@ sv/log_line_verdict_classifier_top_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the line verdict classifier
// Clocked, reset-qualified property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef LOG_LINE_VERDICT_CLASSIFIER_TOP_ASSERT_SVH
`define LOG_LINE_VERDICT_CLASSIFIER_TOP_ASSERT_SVH

// Assert a property on the rising clock edge, disabled while reset is low.
`define LLVC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication form of the same wrapper.
`define LLVC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    `LLVC_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

@@ sv/llvc_pkg.sv @@
// ----------------------------------------------------------------------------
// llvc_pkg
// Types, constants and patterns shared by the line verdict classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package llvc_pkg;

    localparam int LLVC_CHAR_W      = 8;
    localparam int LLVC_WIN_LEN     = 14;
    localparam int LLVC_HEAD_LEN    = 6;
    localparam int LLVC_MIN_LEN     = 8;
    localparam int LLVC_CNT_W       = 4;
    localparam int LLVC_NUM_PAT     = 4;
    localparam int LLVC_QUEUE_DEPTH = 2;
    localparam int LLVC_TDATA_W     = 8;

    localparam logic [8*8-1:0]  PAT_GAP_MARK  = {"teach", "_me"};
    localparam logic [14*8-1:0] PAT_RECOGNISE = "recognize-fail";
    localparam logic [10*8-1:0] PAT_SPELL     = "spell-fail";
    localparam logic [8*8-1:0]  PAT_WAV_NONE  = "wav NONE";

    localparam logic [4*8-1:0]  PRE_SCH   = "sch ";
    localparam logic [6*8-1:0]  PRE_BLOCK = "block ";
    localparam logic [6*8-1:0]  PRE_SIGHT = "sight ";
    localparam logic [6*8-1:0]  PRE_PAINT = "paint ";
    localparam logic [6*8-1:0]  PRE_KNOWN = "known ";

    typedef enum logic [2:0] {
        V_HEALTHY   = 3'd0,
        V_TEACH_GAP = 3'd1,
        V_RETEACH   = 3'd2,
        V_DORMANT   = 3'd3,
        V_DAMAGE    = 3'd4
    } t_verdict;

    typedef struct packed {
        logic     valid;
        t_verdict code;
    } t_verdict_beat;

endpackage

`default_nettype wire

@@ sv/log_line_verdict_classifier_top.sv @@
// ----------------------------------------------------------------------------
// log_line_verdict_classifier_top
// Classifies text lines, one character per beat, into a verdict code.
//
//   Channel   Direction  Payload                                 End marker
//   s_axis    in         tdata[7:0] ch                           tlast
//   m_axis    out        tdata[2:0] verdict_code, [7:3] zero     none
//
// One character is accepted per cycle while the verdict queue has room.
// The verdict of a line enters the queue with its final character and then
// the output register on m_axis; the queue and output register absorb stalls.
// Reset is synchronous and active low, and clears the line state at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module log_line_verdict_classifier_top
    import llvc_pkg::*;
#(
    parameter int QUEUE_DEPTH = LLVC_QUEUE_DEPTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    input  wire logic [LLVC_CHAR_W-1:0]  i_s_axis_tdata,   // [7:0] ch
    input  wire logic                    i_s_axis_tlast,
    output logic                         o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    output logic [LLVC_TDATA_W-1:0]      o_m_axis_tdata    // [2:0] verdict_code
);

    t_verdict_beat push;
    t_verdict_beat head;
    logic          q_full;
    logic          pop;

    llvc_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_s_axis_tready (o_s_axis_tready),
        .i_q_full        (q_full),
        .o_push          (push)
    );

    llvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    llvc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_m_axis_tready (i_m_axis_tready)
    );

endmodule

`default_nettype wire

@@ sv/llvc_front.sv @@
// ----------------------------------------------------------------------------
// llvc_front
// Accepts characters, tracks the window, head and flags, and pushes a
// verdict into the queue on the final character of each line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module llvc_front
    import llvc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    input  wire logic [LLVC_CHAR_W-1:0] i_s_axis_tdata,
    input  wire logic                   i_s_axis_tlast,
    output logic                        o_s_axis_tready,
    input  wire logic                   i_q_full,
    output t_verdict_beat               o_push
);

    localparam int WIN_W  = LLVC_WIN_LEN * LLVC_CHAR_W;
    localparam int HEAD_W = LLVC_HEAD_LEN * LLVC_CHAR_W;

    logic [WIN_W-1:0]        r_win,   n_win;
    logic [HEAD_W-1:0]       r_head,  n_head;
    logic [LLVC_CNT_W-1:0]   r_cnt,   n_cnt;
    logic [LLVC_NUM_PAT-1:0] r_flags, n_flags;
    logic [LLVC_NUM_PAT-1:0] hits;
    logic                    accept;
    logic                    prefix_ok;
    t_verdict                verdict;

    assign o_s_axis_tready = ~i_q_full;
    assign accept          = i_s_axis_tvalid & ~i_q_full;

    // The newest character sits in the lowest byte of the window.
    always_comb begin
        n_win = {r_win[WIN_W-LLVC_CHAR_W-1:0], i_s_axis_tdata};

        hits[0] = (n_win[$bits(PAT_GAP_MARK)-1:0]  == PAT_GAP_MARK);
        hits[1] = (n_win[$bits(PAT_RECOGNISE)-1:0] == PAT_RECOGNISE);
        hits[2] = (n_win[$bits(PAT_SPELL)-1:0]     == PAT_SPELL);
        hits[3] = (n_win[$bits(PAT_WAV_NONE)-1:0]  == PAT_WAV_NONE);
        n_flags = r_flags | hits;

        if (r_cnt < LLVC_CNT_W'(LLVC_MIN_LEN)) begin
            n_cnt = r_cnt + 1'b1;
        end else begin
            n_cnt = r_cnt;
        end

        // The first character of the line is held in the top byte.
        n_head = r_head;
        for (int k = 0; k < LLVC_HEAD_LEN; k++) begin
            if (r_cnt == LLVC_CNT_W'(k)) begin
                n_head[LLVC_CHAR_W*(LLVC_HEAD_LEN-1-k) +: LLVC_CHAR_W] = i_s_axis_tdata;
            end
        end
    end

    always_comb begin
        prefix_ok = (n_head[HEAD_W-1 -: $bits(PRE_SCH)]   == PRE_SCH)   ||
                    (n_head[HEAD_W-1 -: $bits(PRE_BLOCK)] == PRE_BLOCK) ||
                    (n_head[HEAD_W-1 -: $bits(PRE_SIGHT)] == PRE_SIGHT) ||
                    (n_head[HEAD_W-1 -: $bits(PRE_PAINT)] == PRE_PAINT) ||
                    (n_head[HEAD_W-1 -: $bits(PRE_KNOWN)] == PRE_KNOWN);

        if (n_cnt < LLVC_CNT_W'(LLVC_MIN_LEN)) begin
            verdict = V_DAMAGE;
        end else if (n_flags[0]) begin
            verdict = V_TEACH_GAP;
        end else if (n_flags[1] | n_flags[2]) begin
            verdict = V_RETEACH;
        end else if (n_flags[3]) begin
            verdict = V_DORMANT;
        end else if (prefix_ok) begin
            verdict = V_HEALTHY;
        end else begin
            verdict = V_DAMAGE;
        end
    end

    assign o_push = '{valid: accept & i_s_axis_tlast, code: verdict};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_head  <= '0;
            r_cnt   <= '0;
            r_flags <= '0;
        end else if (accept) begin
            if (i_s_axis_tlast) begin
                r_win   <= '0;
                r_head  <= '0;
                r_cnt   <= '0;
                r_flags <= '0;
            end else begin
                r_win   <= n_win;
                r_head  <= n_head;
                r_cnt   <= n_cnt;
                r_flags <= n_flags;
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/llvc_queue.sv @@
// ----------------------------------------------------------------------------
// llvc_queue
// Small verdict queue that decouples the classifier from the output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module llvc_queue
    import llvc_pkg::*;
#(
    parameter int DEPTH = LLVC_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_verdict_beat i_push,
    input  wire logic          i_pop,
    output logic               o_full,
    output t_verdict_beat      o_head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_verdict            r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr, n_wr;
    logic [PTR_W-1:0]    r_rd, n_rd;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full = (r_cnt == CNT_W'(DEPTH));
    assign o_head = '{valid: (r_cnt != '0), code: r_mem[r_rd]};

    assign do_push = i_push.valid & ~o_full;
    assign do_pop  = i_pop & o_head.valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_push.code;
        end
    end

endmodule

`default_nettype wire

@@ sv/llvc_back.sv @@
// ----------------------------------------------------------------------------
// llvc_back
// Output register that takes verdicts from the queue and presents them
// on the master stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module llvc_back
    import llvc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_verdict_beat           i_head,
    output logic                         o_pop,
    output logic                         o_m_axis_tvalid,
    output logic [LLVC_TDATA_W-1:0]      o_m_axis_tdata,
    input  wire logic                    i_m_axis_tready
);

    logic     r_valid;
    t_verdict r_code;

    assign o_pop           = i_head.valid & (~r_valid | i_m_axis_tready);
    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tdata  = {{(LLVC_TDATA_W-$bits(t_verdict)){1'b0}}, r_code};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_code <= i_head.code;
        end
    end

endmodule

`default_nettype wire

@@ sv/llvc_checker.sv @@
// ----------------------------------------------------------------------------
// llvc_checker
// Port-level checks for the line verdict classifier, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "log_line_verdict_classifier_top_assert.svh"

module llvc_checker
    import llvc_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_s_axis_tvalid,
    input  wire logic                    o_s_axis_tready,
    input  wire logic [LLVC_CHAR_W-1:0]  i_s_axis_tdata,
    input  wire logic                    i_s_axis_tlast,
    input  wire logic                    o_m_axis_tvalid,
    input  wire logic                    i_m_axis_tready,
    input  wire logic [LLVC_TDATA_W-1:0] o_m_axis_tdata
);

    logic last_beat;

    assign last_beat = i_s_axis_tvalid & o_s_axis_tready & i_s_axis_tlast;

    `LLVC_ASSERT_IMP(a_code_range, i_clk, i_rst_n, o_m_axis_tvalid,
        o_m_axis_tdata <= LLVC_TDATA_W'(V_DAMAGE), "verdict code out of range")

    `LLVC_ASSERT_IMP(a_pad_zero, i_clk, i_rst_n, o_m_axis_tvalid,
        o_m_axis_tdata[LLVC_TDATA_W-1:$bits(t_verdict)] == '0, "tdata padding not zero")

    `LLVC_ASSERT_IMP(a_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready,
        ##1 o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled verdict changed")

    `LLVC_ASSERT_IMP(a_from_last, i_clk, i_rst_n, $rose(o_m_axis_tvalid),
        $past(last_beat, 2), "verdict without a preceding final character")

endmodule

bind log_line_verdict_classifier_top llvc_checker u_llvc_checker (.*);

`default_nettype wire

@@ verif/log_line_verdict_classifier_top_test.sv @@
// ----------------------------------------------------------------------------
// log_line_verdict_classifier_top_test
// Streams text lines into the classifier one character per beat and checks
// each verdict beat against a line-by-line predictor. A short directed set is
// followed by random lines. These are mostly prefixes, embedded markers,
// near misses, markers split over a line end and long lines, with filler
// between them. They run under four idling regimes on both stream sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module log_line_verdict_classifier_top_test;
    import llvc_pkg::*;

    localparam longint RUN_LIMIT_NS    = 64'd9_600_000;
    localparam int     ITEMS_PER_PHASE = 362;
    localparam int     NUM_PHASES      = 4;
    localparam int     DRAIN_CYCLES    = 16;

    localparam int MARK_TEACH = 0;
    localparam int MARK_RECOG = 1;
    localparam int MARK_SPELL = 2;
    localparam int MARK_WAV   = 3;

    typedef struct packed {
        logic [LLVC_CHAR_W-1:0] ch;
        logic                   eol;
    } t_char_beat;

    logic                    i_clk    = 1'b0;
    logic                    i_rst_n  = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [LLVC_CHAR_W-1:0]  s_tdata  = '0;
    logic                    s_tlast  = 1'b0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [LLVC_TDATA_W-1:0] m_tdata;

    t_char_beat             chars_to_send[$];
    t_verdict               due_verdicts[$];
    logic [LLVC_CHAR_W-1:0] line_buf[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int queued_items   = 0;
    int mismatch_count = 0;

    logic [LLVC_WIN_LEN*8-1:0]  line_tail  = '0;
    logic [LLVC_HEAD_LEN*8-1:0] line_head  = '0;
    logic [LLVC_CNT_W-1:0]      line_len   = '0;
    logic [LLVC_NUM_PAT-1:0]    seen_marks = '0;

    string pattern_text[4] = '{{"teach", "_me"}, "recognize-fail", "spell-fail", "wav NONE"};
    string prefix_text[5]  = '{"sch ", "block ", "sight ", "paint ", "known "};
    string near_alphabet   = "teach_mrognize-fa lspwvNOE";

    log_line_verdict_classifier_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] ch
        .i_s_axis_tlast  (s_tlast),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)    // [2:0] verdict_code, [7:3] zero
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic t_verdict line_verdict();
        logic known_prefix;
        known_prefix = (line_head[LLVC_HEAD_LEN*8-1 -: 32] == PRE_SCH)
                    || (line_head == PRE_BLOCK) || (line_head == PRE_SIGHT)
                    || (line_head == PRE_PAINT) || (line_head == PRE_KNOWN);
        if (line_len < LLVC_MIN_LEN)
            return V_DAMAGE;
        if (seen_marks[MARK_TEACH])
            return V_TEACH_GAP;
        if (seen_marks[MARK_RECOG] || seen_marks[MARK_SPELL])
            return V_RETEACH;
        if (seen_marks[MARK_WAV])
            return V_DORMANT;
        return known_prefix ? V_HEALTHY : V_DAMAGE;
    endfunction

    function automatic void classify_char(input logic [LLVC_CHAR_W-1:0] c, input logic eol);
        line_tail = {line_tail[(LLVC_WIN_LEN-1)*8-1:0], c};
        if (line_len < LLVC_HEAD_LEN)
            line_head[(LLVC_HEAD_LEN-1-line_len)*8 +: 8] = c;
        if (line_len < LLVC_MIN_LEN)
            line_len = line_len + 1'b1;
        if (line_tail[8*8-1:0] == PAT_GAP_MARK)
            seen_marks[MARK_TEACH] = 1'b1;
        if (line_tail[14*8-1:0] == PAT_RECOGNISE)
            seen_marks[MARK_RECOG] = 1'b1;
        if (line_tail[10*8-1:0] == PAT_SPELL)
            seen_marks[MARK_SPELL] = 1'b1;
        if (line_tail[8*8-1:0] == PAT_WAV_NONE)
            seen_marks[MARK_WAV] = 1'b1;
        if (eol) begin
            due_verdicts.push_back(line_verdict());
            line_tail  = '0;
            line_head  = '0;
            line_len   = '0;
            seen_marks = '0;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic logic [7:0] rand_char(input bit wide);
        if (wide || $urandom_range(0, 3) == 0)
            return 8'($urandom_range(1, 255));
        if ($urandom_range(0, 2) == 0)
            return near_alphabet[$urandom_range(0, near_alphabet.len() - 1)];
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endfunction

    function automatic void add_noise(input int n, input bit wide);
        for (int i = 0; i < n; i++)
            line_buf.push_back(rand_char(wide));
    endfunction

    function automatic void flush_line();
        t_char_beat beat;
        for (int i = 0; i < line_buf.size(); i++) begin
            beat.ch  = line_buf[i];
            beat.eol = (i == line_buf.size() - 1);
            chars_to_send.push_back(beat);
        end
        queued_items += line_buf.size();
        line_buf.delete();
    endfunction

    function automatic void add_random_line();
        int    kind;
        int    p;
        string s;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            add_noise($urandom_range(1, 9), 1'b0);
        end else if (kind < 35) begin
            add_text(prefix_text[$urandom_range(0, 4)]);
            add_noise($urandom_range(0, 10), 1'b0);
        end else if (kind < 65) begin
            if ($urandom_range(0, 1))
                add_text(prefix_text[$urandom_range(0, 4)]);
            else
                add_noise($urandom_range(0, 4), 1'b0);
            add_text(pattern_text[$urandom_range(0, 3)]);
            if ($urandom_range(0, 2) == 0)
                add_text(pattern_text[$urandom_range(0, 3)]);
            add_noise($urandom_range(0, 5), 1'b0);
        end else if (kind < 75) begin
            if ($urandom_range(0, 1))
                s = pattern_text[$urandom_range(0, 3)];
            else
                s = prefix_text[$urandom_range(0, 4)];
            p = $urandom_range(0, s.len() - 1);
            s[p] = s[p] ^ (8'd1 << $urandom_range(0, 7));
            add_noise($urandom_range(0, 3), 1'b0);
            add_text(s);
            add_noise($urandom_range(0, 6), 1'b0);
        end else if (kind < 82) begin
            s = pattern_text[$urandom_range(0, 3)];
            p = $urandom_range(1, s.len() - 1);
            add_noise($urandom_range(0, 8), 1'b0);
            add_text(s.substr(0, p - 1));
            flush_line();
            add_text(s.substr(p, s.len() - 1));
            add_noise($urandom_range(0, 8), 1'b0);
        end else if (kind < 90) begin
            if ($urandom_range(0, 1))
                add_text(prefix_text[$urandom_range(0, 4)]);
            add_noise($urandom_range(14, 40), 1'b0);
            if ($urandom_range(0, 1))
                add_text(pattern_text[$urandom_range(0, 3)]);
            add_noise($urandom_range(0, 20), 1'b0);
        end else begin
            add_noise($urandom_range(1, 16), 1'b1);
        end
        flush_line();
    endfunction

    always @(posedge i_clk) begin
        t_char_beat beat;
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                classify_char(s_tdata, s_tlast);
            if (!s_tvalid || s_tready) begin
                if (chars_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    beat = chars_to_send.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= beat.ch;
                    s_tlast  <= beat.eol;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (due_verdicts.size() == 0) begin
                report_mismatch($sformatf("verdict beat 0x%02h with no line pending", m_tdata));
            end else begin
                want = due_verdicts.pop_front();
                if (m_tdata[2:0] !== want || m_tdata[LLVC_TDATA_W-1:3] !== '0)
                    report_mismatch($sformatf("verdict beat 0x%02h, predicted %s",
                                              m_tdata, want.name()));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            @(negedge i_clk);
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            if (phase == 0) begin
                line_buf.push_back(8'hff);
                flush_line();
                add_text({"teach", "_me"});
                flush_line();
                add_text("wav NONE");
                flush_line();
                // A zero byte counts towards the length but matches nothing.
                add_text("sch ");
                line_buf.push_back(8'h00);
                add_text("xyz");
                flush_line();
            end
            while (queued_items < ITEMS_PER_PHASE * (phase + 1))
                add_random_line();
            // Hold the sender until every verdict of this phase has arrived.
            do
                @(negedge i_clk);
            while (chars_to_send.size() > 0 || s_tvalid || due_verdicts.size() > 0);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("log_line_verdict_classifier_top: match");
        else
            $display("log_line_verdict_classifier_top: mismatch");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("log_line_verdict_classifier_top: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+sv
sv/llvc_pkg.sv
sv/llvc_front.sv
sv/llvc_queue.sv
sv/llvc_back.sv
sv/log_line_verdict_classifier_top.sv
sv/llvc_checker.sv
verif/log_line_verdict_classifier_top_test.sv
